/* rtl/core/pdce_pkg.sv */
// ----------------------------------------------------------------------------
// pdce_pkg: shared types and constants for the polygon delta coordinate encoder
// Widths, lane result and merge status structures used by all core files.
// ----------------------------------------------------------------------------
package pdce_pkg;

    localparam int COORD_W    = 23;           // vertex coordinate width
    localparam int DIFF_W     = COORD_W + 1;  // full precision difference
    localparam int BYTE_W     = 8;
    localparam int SHORT_W    = 7;            // payload bits of a short code
    localparam int LANE_BYTES = 3;            // bytes of a long code
    localparam int MAX_BYTES  = 2 * LANE_BYTES;
    localparam int CNT_W      = $clog2(MAX_BYTES + 1);
    localparam int IDX_W      = $clog2(MAX_BYTES);

    // Long code markers and bit fields
    localparam logic LONG_MARK  = 1'b1;
    localparam logic SHORT_MARK = 1'b0;
    localparam int   MID_LSB    = 7;
    localparam int   HIGH_LSB   = 15;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [BYTE_W-1:0]  byte_t;
    typedef logic        [CNT_W-1:0]   cnt_t;
    typedef logic        [IDX_W-1:0]   idx_t;

    // One coordinate lane's encoding
    typedef struct packed {
        logic                         is_long;
        byte_t [LANE_BYTES-1:0]       data;
    } lane_res_t;

    // Merge stage status seen by the top level
    typedef struct packed {
        logic ready;
        cnt_t pending;
    } merge_status_t;

endpackage

/* rtl/core/pdce_in_if.sv */
// ----------------------------------------------------------------------------
// pdce_in_if: vertex input channel
// Valid/ready channel carrying one polygon vertex per item.
// ----------------------------------------------------------------------------
interface pdce_in_if
    import pdce_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    logic   first_point;

    modport source (output valid, output point_x, output point_y,
                    output first_point, input ready);
    modport sink   (input valid, input point_x, input point_y,
                    input first_point, output ready);
endinterface

/* rtl/core/pdce_out_if.sv */
// ----------------------------------------------------------------------------
// pdce_out_if: encoded byte output channel
// Valid/ready channel carrying one encoded byte per item.
// ----------------------------------------------------------------------------
interface pdce_out_if
    import pdce_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

/* rtl/core/pdce_lane.sv */
// ----------------------------------------------------------------------------
// pdce_lane: single coordinate encoder lane
// Forms the delta against the previous value and builds the short or long code.
// ----------------------------------------------------------------------------
module pdce_lane
    import pdce_pkg::*;
(
    input  coord_t    prev,
    input  coord_t    now,
    output lane_res_t res
);

    logic [DIFF_W-1:0] diff;
    logic              fits;

    // Full precision difference, sign extended by one bit
    assign diff = {now[COORD_W-1], now} - {prev[COORD_W-1], prev};

    // Short range -64..63: all bits above the 7-bit field match the sign
    assign fits = (&diff[DIFF_W-1:SHORT_W-1]) | ~(|diff[DIFF_W-1:SHORT_W-1]);

    always_comb
    begin
        res.is_long = ~fits;
        if (fits)
        begin
            res.data[0] = {SHORT_MARK, diff[SHORT_W-1:0]};
            res.data[1] = '0;
            res.data[2] = '0;
        end
        else
        begin
            res.data[0] = {LONG_MARK, now[SHORT_W-1:0]};
            res.data[1] = now[HIGH_LSB-1:MID_LSB];
            res.data[2] = now[COORD_W-1:HIGH_LSB];
        end
    end

endmodule

/* rtl/core/pdce_merge.sv */
// ----------------------------------------------------------------------------
// pdce_merge: lane merge and byte serializer
// Packs the x and y lane codes into one vertex buffer and sends it out one
// byte per cycle while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module pdce_merge
    import pdce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lane_res_t         lane_x,
    input  lane_res_t         lane_y,
    output merge_status_t     stat,
    pdce_out_if.source        code
);

    byte_t [MAX_BYTES-1:0] merged;
    cnt_t                  merged_cnt;

    byte_t [MAX_BYTES-1:0] bytes_reg;
    cnt_t                  cnt_reg, cnt_next;
    idx_t                  idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    byte_t                 out_byte_reg;
    logic                  last_reg;

    logic                  load_out;
    logic                  take;
    logic                  in_ready;
    logic                  accept;

    // Lay out x bytes then y bytes
    always_comb
    begin
        if (lane_x.is_long)
        begin
            merged = {lane_y.data, lane_x.data};
        end
        else
        begin
            merged = {byte_t'(0), byte_t'(0), lane_y.data, lane_x.data[0]};
        end
        merged_cnt = cnt_t'(lane_x.is_long ? LANE_BYTES : 1)
                   + cnt_t'(lane_y.is_long ? LANE_BYTES : 1);
    end

    // Handshake: output stage refills when empty or drained
    assign load_out = ~out_valid_reg | code.ready;
    assign take     = load_out & (cnt_reg != '0);
    assign in_ready = (cnt_reg == '0) | ((cnt_reg == cnt_t'(1)) & load_out);
    assign accept   = in_valid & in_ready;

    // Buffer count and read index
    always_comb
    begin
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            cnt_next       = cnt_reg - cnt_t'(1);
            idx_next       = idx_reg + idx_t'(1);
            out_valid_next = 1'b1;
        end
        else if (load_out)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            cnt_next = merged_cnt;
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bytes_reg <= merged;
        end
        if (take)
        begin
            out_byte_reg <= bytes_reg[idx_reg];
            last_reg     <= (cnt_reg == cnt_t'(1));
        end
    end

    assign code.valid     = out_valid_reg;
    assign code.out_byte  = out_byte_reg;
    assign code.last_byte = last_reg;

    assign stat.ready   = in_ready;
    assign stat.pending = cnt_reg;

endmodule

/* rtl/core/polygon_delta_coord_encoder_core.sv */
// ----------------------------------------------------------------------------
// polygon_delta_coord_encoder_core: polygon vertex delta coordinate encoder
// Two lanes encode x and y against the previous vertex in parallel; a merge
// stage serializes the 2 to 6 resulting bytes and marks the last one.
// ----------------------------------------------------------------------------
// Flow: a taken vertex is registered in the byte buffer, then its first byte is
//   moved into the registered output stage when that stage is free.
// Output: bytes leave through the single byte-wide output stage as the receiver
//   takes them; the next vertex is taken with the last byte.
// Reset: asynchronous active low; clears previous coordinates to zero and
//   empties the byte buffer and output stage.
module polygon_delta_coord_encoder_core
    import pdce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pdce_in_if.sink    vertex,
    pdce_out_if.source code
);

    coord_t        prev_x_reg;
    coord_t        prev_y_reg;
    coord_t        base_x;
    coord_t        base_y;
    lane_res_t     lane_x;
    lane_res_t     lane_y;
    merge_status_t stat;
    logic          accept;

    assign accept       = vertex.valid & stat.ready;
    assign vertex.ready = stat.ready;

    // A first vertex encodes against zero
    assign base_x = vertex.first_point ? coord_t'(0) : prev_x_reg;
    assign base_y = vertex.first_point ? coord_t'(0) : prev_y_reg;

    pdce_lane u_lane_x
    (
        .prev (base_x),
        .now  (vertex.point_x),
        .res  (lane_x)
    );

    pdce_lane u_lane_y
    (
        .prev (base_y),
        .now  (vertex.point_y),
        .res  (lane_y)
    );

    pdce_merge u_merge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vertex.valid),
        .lane_x   (lane_x),
        .lane_y   (lane_y),
        .stat     (stat),
        .code     (code)
    );

    // Previous vertex
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end
        else if (accept)
        begin
            prev_x_reg <= vertex.point_x;
            prev_y_reg <= vertex.point_y;
        end
    end

    // Buffer never holds more than one vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.pending <= cnt_t'(MAX_BYTES))
    else $error("byte buffer count out of range");

    // A taken vertex loads at least two bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> stat.pending >= cnt_t'(2))
    else $error("vertex taken without loading its bytes");

    // A taken vertex has the output stage busy once the byte buffer has been loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 code.valid)
    else $error("output stage empty after vertex taken");

    // Previous coordinates track the taken vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (prev_x_reg == $past(vertex.point_x))
                && (prev_y_reg == $past(vertex.point_y)))
    else $error("previous vertex not updated");

endmodule
